// ----- rtl/core/kfs_pkg.sv -----
package kfs_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned DUR_W = 31;
    localparam int unsigned WEIGHT_W = 17;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned DIV_W = TIME_W + FRAC_W + 1;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_SAMPLE = 2'd2,
        MODE_RSVD   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_DURATION = 2'd0,
        CFG_LOOP     = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } vec3_t;

    typedef struct packed {
        logic start;
        logic signed [DIV_W-1:0] num;
        logic signed [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [DIV_W-1:0] quo;
        logic signed [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

// ----- rtl/core/kfs_divider.sv -----
module kfs_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  kfs_pkg::div_req_t   req,
    output kfs_pkg::div_rsp_t   rsp
);

    localparam int unsigned W = kfs_pkg::DIV_W;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0] num_mag_reg, num_mag_next;
    logic [W-1:0] den_mag_reg, den_mag_next;
    logic [W-1:0] rem_reg, rem_next;
    logic         neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [W:0]   shifted;
    logic [W:0]   trial;

    always_comb begin
        shifted = {rem_reg, num_mag_reg[W-1]};
        trial = shifted - {1'b0, den_mag_reg};
    end

    // Restoring divide on magnitudes, one quotient bit per cycle; the
    // remainder takes the sign of the dividend (truncating division).
    always_comb begin
        num_mag_next = num_mag_reg;
        den_mag_next = den_mag_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            num_mag_next = req.num[W-1] ? W'(-req.num) : W'(req.num);
            den_mag_next = req.den[W-1] ? W'(-req.den) : W'(req.den);
            neg_next = req.num[W-1];
            rem_next = '0;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                num_mag_next = {num_mag_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                num_mag_next = {num_mag_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_mag_reg <= num_mag_next;
        den_mag_reg <= den_mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo = num_mag_reg;
    assign rsp.rem = neg_reg ? -$signed(rem_reg) : $signed(rem_reg);

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start) else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("divider done held");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg)) else $error("done without work");

endmodule

// ----- rtl/core/keyframe_vec3_sampler.sv -----
// Keyframe track sampler for xyz values in signed Q16.16.
// Input items arrive on the s_axis channel. s_axis_tdata carries the mode
// (clear, append, sample), the time and the x, y and z values. Clear and
// append update the track and produce no transfer on m_axis. A sample
// produces one m_axis transfer with the interpolated xyz and a flag in
// m_axis_tuser that marks a fallback result from an empty track.
// Configuration registers (clip duration, loop enable) are written through
// cfg_wr_en, cfg_addr and cfg_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce. Items are handled
// one at a time. A sample runs a serial division for the wrap remainder when
// looping, an interval search with one key memory read per cycle, a serial
// division for the weight unless the weight is clamped, and the mix
// multiplies.
// Reset empties the track and clears the configuration registers; key
// memories are not cleared. When the receiver stalls, the result waits in the
// output register and no new item is taken until it has been transferred.
module keyframe_vec3_sampler #(
    parameter int unsigned MAX_KEYS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], item_time[33:2], value_x[65:34], value_y[97:66],
    // value_z[129:98], zero fill up to bit 135
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_axis_tdata,
    // used_fallback
    output logic         m_axis_tuser,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [30:0]  cfg_wdata
);

    localparam int unsigned AW = $clog2(MAX_KEYS);
    localparam int unsigned CW = $clog2(MAX_KEYS + 1);
    localparam int unsigned TW = kfs_pkg::TIME_W;
    localparam int unsigned VW = kfs_pkg::VAL_W;
    localparam int unsigned WW = kfs_pkg::WEIGHT_W;
    localparam int unsigned FW = kfs_pkg::FRAC_W;
    localparam int unsigned DVW = kfs_pkg::DIV_W;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_WRAP   = 11'b00000000010,
        ST_NORM   = 11'b00000000100,
        ST_RDFST  = 11'b00000001000,
        ST_RDLST  = 11'b00000010000,
        ST_DECIDE = 11'b00000100000,
        ST_SEARCH = 11'b00001000000,
        ST_PAIR   = 11'b00010000000,
        ST_DIV    = 11'b00100000000,
        ST_MUL    = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [kfs_pkg::DUR_W-1:0] dur_reg;
    logic loop_reg;
    logic [CW-1:0] count_reg, count_next;

    logic [TW-1:0] mem_t [MAX_KEYS];
    kfs_pkg::vec3_t mem_v [MAX_KEYS];
    logic [AW-1:0] rd_addr;
    logic rd_en;
    logic signed [TW-1:0] rd_t_reg;
    kfs_pkg::vec3_t rd_v_reg;

    logic signed [TW-1:0] t_reg, t_next;
    kfs_pkg::vec3_t fb_reg, fb_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic signed [TW-1:0] ta_reg, ta_next;
    kfs_pkg::vec3_t va_reg, va_next;
    kfs_pkg::vec3_t vb_reg, vb_next;
    logic [WW-1:0] w_reg, w_next;
    kfs_pkg::vec3_t res_reg, res_next;
    logic fbflag_reg, fbflag_next;
    logic ovalid_reg, ovalid_next;
    logic signed [TW+WW:0] px_reg, py_reg, pz_reg;
    logic mul_ph_reg, mul_ph_next;

    kfs_pkg::div_req_t dreq;
    kfs_pkg::div_rsp_t drsp;

    kfs_pkg::mode_t in_mode;
    logic signed [TW-1:0] in_time;
    kfs_pkg::vec3_t in_val;
    logic in_fire;

    assign in_mode = kfs_pkg::mode_t'(s_axis_tdata[1:0]);
    assign in_time = s_axis_tdata[33:2];
    assign in_val = '{x: s_axis_tdata[65:34], y: s_axis_tdata[97:66], z: s_axis_tdata[129:98]};
    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    kfs_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (dreq),
        .rsp    (drsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg <= '0;
            loop_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            if (kfs_pkg::cfg_index_t'({1'b0, cfg_addr}) == kfs_pkg::CFG_DURATION) begin
                dur_reg <= cfg_wdata;
            end else begin
                loop_reg <= cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_mode == kfs_pkg::MODE_APPEND && count_reg < CW'(MAX_KEYS)) begin
            mem_t[count_reg[AW-1:0]] <= in_time;
            mem_v[count_reg[AW-1:0]] <= in_val;
        end
        if (rd_en) begin
            rd_t_reg <= mem_t[rd_addr];
            rd_v_reg <= mem_v[rd_addr];
        end
    end

    logic signed [TW:0] t_ext, d_ext, rem_adj;
    logic signed [TW:0] tb_ext, dnum, dden;
    logic signed [VW:0] dx, dy, dz;
    logic signed [VW+WW+1:0] mx, my, mz;

    always_comb begin
        t_ext = {t_reg[TW-1], t_reg};
        d_ext = {2'b00, dur_reg};
        rem_adj = drsp.rem[DVW-1] ? (TW+1)'(drsp.rem) + d_ext : (TW+1)'(drsp.rem);
        tb_ext = {rd_t_reg[TW-1], rd_t_reg};
        dnum = t_ext - {ta_reg[TW-1], ta_reg};
        dden = tb_ext - {ta_reg[TW-1], ta_reg};
        dx = {vb_reg.x[VW-1], vb_reg.x} - {va_reg.x[VW-1], va_reg.x};
        dy = {vb_reg.y[VW-1], vb_reg.y} - {va_reg.y[VW-1], va_reg.y};
        dz = {vb_reg.z[VW-1], vb_reg.z} - {va_reg.z[VW-1], va_reg.z};
        mx = dx * $signed({1'b0, w_reg});
        my = dy * $signed({1'b0, w_reg});
        mz = dz * $signed({1'b0, w_reg});
    end

    always_ff @(posedge aclk) begin
        px_reg <= (TW+WW+1)'(mx);
        py_reg <= (TW+WW+1)'(my);
        pz_reg <= (TW+WW+1)'(mz);
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        t_next = t_reg;
        fb_next = fb_reg;
        idx_next = idx_reg;
        ta_next = ta_reg;
        va_next = va_reg;
        vb_next = vb_reg;
        w_next = w_reg;
        res_next = res_reg;
        fbflag_next = fbflag_reg;
        ovalid_next = ovalid_reg;
        mul_ph_next = mul_ph_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        dreq = '{start: 1'b0, num: '0, den: '0};
        if (ovalid_reg && m_axis_tready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    priority case (in_mode)
                        kfs_pkg::MODE_CLEAR: count_next = '0;
                        kfs_pkg::MODE_APPEND: begin
                            if (count_reg < CW'(MAX_KEYS)) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        kfs_pkg::MODE_SAMPLE: begin
                            fb_next = in_val;
                            t_next = in_time;
                            if (dur_reg == '0) begin
                                t_next = '0;
                                state_next = ST_RDFST;
                            end else if (loop_reg) begin
                                dreq = '{start: 1'b1,
                                    num: {{(DVW-TW){in_time[TW-1]}}, in_time},
                                    den: {{(DVW-kfs_pkg::DUR_W){1'b0}}, dur_reg}};
                                state_next = ST_WRAP;
                            end else begin
                                state_next = ST_NORM;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WRAP: begin
                if (drsp.done) begin
                    t_next = TW'(rem_adj);
                    state_next = ST_RDFST;
                end
            end
            ST_NORM: begin
                if (t_reg[TW-1]) begin
                    t_next = '0;
                end else if (t_ext > d_ext) begin
                    t_next = TW'(d_ext);
                end
                state_next = ST_RDFST;
            end
            ST_RDFST: begin
                if (count_reg == '0) begin
                    res_next = fb_reg;
                    fbflag_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = '0;
                    state_next = ST_RDLST;
                end
            end
            ST_RDLST: begin
                if (count_reg == CW'(1) || t_reg <= rd_t_reg) begin
                    res_next = rd_v_reg;
                    fbflag_next = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = AW'(count_reg - 1'b1);
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (t_reg >= rd_t_reg) begin
                    res_next = rd_v_reg;
                    fbflag_next = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = AW'(1);
                    idx_next = AW'(1);
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (t_reg <= rd_t_reg || idx_reg == AW'(count_reg - 1'b1)) begin
                    vb_next = rd_v_reg;
                    rd_en = 1'b1;
                    rd_addr = idx_reg - 1'b1;
                    state_next = ST_PAIR;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_PAIR: begin
                ta_next = rd_t_reg;
                va_next = rd_v_reg;
                rd_en = 1'b1;
                rd_addr = idx_reg;
                state_next = ST_DIV;
                mul_ph_next = 1'b0;
            end
            ST_DIV: begin
                if (!mul_ph_reg) begin
                    mul_ph_next = 1'b1;
                    if (dden <= 0 || dnum <= 0) begin
                        w_next = '0;
                        state_next = ST_MUL;
                    end else if (dnum >= dden) begin
                        w_next = WW'(1 << FW);
                        state_next = ST_MUL;
                    end else begin
                        dreq = '{start: 1'b1, num: {dnum, {FW{1'b0}}},
                            den: {{(DVW-TW-1){dden[TW]}}, dden}};
                    end
                end else if (drsp.done) begin
                    w_next = WW'(drsp.quo);
                    state_next = ST_MUL;
                end
                mul_ph_next = (state_next == ST_MUL) ? 1'b0 : 1'b1;
            end
            ST_MUL: begin
                if (!mul_ph_reg) begin
                    mul_ph_next = 1'b1;
                end else begin
                    res_next.x = va_reg.x + VW'(px_reg >>> FW);
                    res_next.y = va_reg.y + VW'(py_reg >>> FW);
                    res_next.z = va_reg.z + VW'(pz_reg >>> FW);
                    fbflag_next = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!ovalid_reg) begin
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        t_reg <= t_next;
        fb_reg <= fb_next;
        idx_reg <= idx_next;
        ta_reg <= ta_next;
        va_reg <= va_next;
        vb_reg <= vb_next;
        w_reg <= w_next;
        res_reg <= res_next;
        fbflag_reg <= fbflag_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovalid_reg <= 1'b0;
            mul_ph_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovalid_reg <= ovalid_next;
            mul_ph_reg <= mul_ph_next;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {res_reg.z, res_reg.y, res_reg.x};
    assign m_axis_tuser = fbflag_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_KEYS)) else $error("key count overflow");
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_out_from_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovalid_reg) |-> $past(state_reg == ST_OUT)) else $error("stray result");
    a_count_stable_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> $stable(count_reg)) else $error("count changed");

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_KEYS = 64;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        fb;
    } sample_t;

    typedef struct {
        kfs_pkg::mode_t mode;
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          typed;
        sample_t     want;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_wr_en;
    logic         cfg_addr;
    logic [30:0]  cfg_wdata;

    keyframe_vec3_sampler #(.MAX_KEYS(MAX_KEYS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Predictor state.
    longint     clip_len;
    bit         wrap_on;
    int         track_len;
    logic [31:0] track_t [MAX_KEYS];
    logic [31:0] track_x [MAX_KEYS];
    logic [31:0] track_y [MAX_KEYS];
    logic [31:0] track_z [MAX_KEYS];

    sample_t pending_samples[$];
    int errors, accepted, produced, fallbacks, mixes, idle_cycles;
    bit no_idle, hold_off, timed_out;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint floor16(longint v);
        if (v >= 0) return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint w);
        longint sa, sb;
        sa = longint'($signed(a));
        sb = longint'($signed(b));
        return 32'(sa + floor16((sb - sa) * w));
    endfunction

    task automatic apply_item(kfs_pkg::mode_t m, logic [31:0] ti, logic [31:0] vx,
                              logic [31:0] vy, logic [31:0] vz);
        longint t, ta, dur, num, w;
        int i;
        sample_t s;
        case (m)
            kfs_pkg::MODE_CLEAR: track_len = 0;
            kfs_pkg::MODE_APPEND: begin
                if (track_len < MAX_KEYS) begin
                    track_t[track_len] = ti;
                    track_x[track_len] = vx;
                    track_y[track_len] = vy;
                    track_z[track_len] = vz;
                    track_len++;
                end
            end
            kfs_pkg::MODE_SAMPLE: begin
                t = longint'($signed(ti));
                if (clip_len <= 0) t = 0;
                else if (wrap_on) begin
                    t = t % clip_len;
                    if (t < 0) t += clip_len;
                end else if (t < 0) t = 0;
                else if (t > clip_len) t = clip_len;
                s.fb = 0;
                if (track_len == 0) begin
                    s.x = vx; s.y = vy; s.z = vz; s.fb = 1;
                end else if (track_len == 1 || t <= longint'($signed(track_t[0]))) begin
                    s.x = track_x[0]; s.y = track_y[0]; s.z = track_z[0];
                end else if (t >= longint'($signed(track_t[track_len-1]))) begin
                    s.x = track_x[track_len-1];
                    s.y = track_y[track_len-1];
                    s.z = track_z[track_len-1];
                end else begin
                    i = track_len - 2;
                    for (int k = 0; k + 1 < track_len; k++) begin
                        if (t <= longint'($signed(track_t[k+1]))) begin
                            i = k;
                            break;
                        end
                    end
                    ta = longint'($signed(track_t[i]));
                    dur = longint'($signed(track_t[i+1])) - ta;
                    num = t - ta;
                    if (dur <= 0 || num <= 0) w = 0;
                    else if (num >= dur) w = 65536;
                    else w = (num * 65536) / dur;
                    s.x = blend(track_x[i], track_x[i+1], w);
                    s.y = blend(track_y[i], track_y[i+1], w);
                    s.z = blend(track_z[i], track_z[i+1], w);
                    mixes++;
                end
                pending_samples.push_back(s);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on %s at result %0d: got %h, want %h", what, produced, got, want);
    endtask

    // Result checker and receiver idling.
    always @(posedge aclk) begin
        sample_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                errors++;
                $display("result %0d arrived with nothing expected", produced);
            end else begin
                w = pending_samples.pop_front();
                if (m_axis_tdata[31:0] !== w.x) report_mismatch("out_x", m_axis_tdata[31:0], w.x);
                if (m_axis_tdata[63:32] !== w.y) report_mismatch("out_y", m_axis_tdata[63:32], w.y);
                if (m_axis_tdata[95:64] !== w.z) report_mismatch("out_z", m_axis_tdata[95:64], w.z);
                if (m_axis_tuser !== w.fb) report_mismatch("used_fallback", 32'(m_axis_tuser), 32'(w.fb));
                if (w.fb) fallbacks++;
            end
            produced++;
        end
    end

    initial begin : receiver
        int n;
        m_axis_tready <= 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 0;
                n = 0;
                while (n < 800) begin
                    @(posedge aclk);
                    n++;
                end
                hold_off = 0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("keyframe_vec3_sampler verification failed");
            $finish;
        end
    end

    task automatic write_reg(kfs_pkg::cfg_index_t idx, logic [30:0] val);
        cfg_wr_en <= 1;
        cfg_addr <= idx[0];
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
        if (idx == kfs_pkg::CFG_DURATION) clip_len = longint'(val);
        else wrap_on = val[0];
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (2 * MAX_KEYS + 100) @(posedge aclk);
    endtask

    task automatic send(kfs_pkg::mode_t m, logic [31:0] ti, logic [31:0] vx,
                        logic [31:0] vy, logic [31:0] vz);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {6'd0, vz, vy, vx, ti, 2'(m)};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        accepted++;
        apply_item(m, ti, vx, vy, vz);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic build_track(int nkeys, logic [31:0] span);
        logic [31:0] t;
        t = 32'($urandom_range(0, 1 << 16)) - 32'(1 << 15);
        send(kfs_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
        for (int k = 0; k < nkeys; k++) begin
            send(kfs_pkg::MODE_APPEND, t, rnd_val(), rnd_val(), rnd_val());
            case ($urandom_range(0, 9))
                0: ;
                1: t = t - 32'($urandom_range(1, 1000));
                default: t = t + 32'($urandom_range(1, span));
            endcase
        end
    endtask

    row_t rows[$];

    task automatic add_row(kfs_pkg::mode_t m, logic [31:0] ti, logic [31:0] vx,
                           logic [31:0] vy, logic [31:0] vz, bit typed, sample_t w);
        row_t r;
        r.mode = m; r.t = ti; r.x = vx; r.y = vy; r.z = vz; r.typed = typed; r.want = w;
        rows.push_back(r);
    endtask

    initial begin : sender
        sample_t none, s;
        int nk, durs[5];
        aresetn <= 0;
        s_axis_tvalid <= 0;
        s_axis_tdata <= '0;
        cfg_wr_en <= 0;
        cfg_addr <= 0;
        cfg_wdata <= '0;
        clip_len = 0; wrap_on = 0; track_len = 0;
        errors = 0; accepted = 0; produced = 0; fallbacks = 0; mixes = 0; idle_cycles = 0;
        no_idle = 0; hold_off = 0;
        none = '{default: 0};
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed table; duration zero forces time to zero after reset.
        add_row(kfs_pkg::MODE_SAMPLE, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h0, 1,
                '{32'h7fffffff, 32'h80000000, 32'h0, 1});
        add_row(kfs_pkg::MODE_RSVD, 32'h5, 32'h1, 32'h2, 32'h3, 0, none);
        add_row(kfs_pkg::MODE_APPEND, 32'h0, 32'h11, 32'h22, 32'h33, 0, none);
        add_row(kfs_pkg::MODE_SAMPLE, 32'h80000000, 32'h0, 32'h0, 32'h0, 1,
                '{32'h11, 32'h22, 32'h33, 0});
        add_row(kfs_pkg::MODE_APPEND, 32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0,
                none);
        add_row(kfs_pkg::MODE_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 0, none);
        add_row(kfs_pkg::MODE_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                0, none);
        add_row(kfs_pkg::MODE_SAMPLE, 32'h1234, 32'h5, 32'h6, 32'h7, 1,
                '{32'h5, 32'h6, 32'h7, 1});
        foreach (rows[i]) begin
            send(rows[i].mode, rows[i].t, rows[i].x, rows[i].y, rows[i].z);
            if (rows[i].typed) begin
                s = pending_samples[$];
                if (s != rows[i].want) begin
                    errors++;
                    $display("predictor disagrees with table row %0d", i);
                end
            end
        end
        drain();

        // Clamping and wrapping over a short track, including full-track drops.
        durs = '{0, 1, 32'h00030000, 32'h7fffffff, 32'h00018000};
        for (int phase = 0; phase < 10; phase++) begin
            write_reg(kfs_pkg::CFG_DURATION, 31'(durs[phase % 5]));
            write_reg(kfs_pkg::CFG_LOOP, 31'(phase % 2));
            nk = (phase == 3) ? MAX_KEYS + 3 : $urandom_range(0, 6);
            build_track(nk, 32'h00010000);
            for (int j = 0; j < 8; j++)
                send(kfs_pkg::MODE_SAMPLE,
                     (j < 2) ? ((j == 0) ? 32'h80000000 : 32'h7fffffff)
                             : 32'($signed($urandom_range(0, 32'h00050000)) - 32'h00010000),
                     rnd_val(), rnd_val(), rnd_val());
            if (phase == 5) begin
                hold_off = 1;
                for (int j = 0; j < 6; j++)
                    send(kfs_pkg::MODE_SAMPLE, $urandom, $urandom, $urandom, $urandom);
            end
            drain();
        end

        // Random part: mostly built tracks with sampling, some noise.
        while (accepted < 1000) begin
            if ($urandom_range(0, 3) == 0) begin
                write_reg(kfs_pkg::CFG_DURATION,
                          ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                      : 31'($urandom_range(0, 32'h00080000)));
                write_reg(kfs_pkg::CFG_LOOP, 31'($urandom_range(0, 1)));
            end
            if (accepted > 850) no_idle = 1;
            nk = ($urandom_range(0, 9) == 0) ? $urandom_range(8, MAX_KEYS + 2)
                                              : $urandom_range(0, 6);
            build_track(nk, $urandom_range(1, 32'h00020000));
            for (int j = 0; j < 12; j++) begin
                case ($urandom_range(0, 9))
                    0: send(kfs_pkg::mode_t'($urandom_range(0, 3)), $urandom, $urandom,
                            $urandom, $urandom);
                    1: send(kfs_pkg::MODE_SAMPLE, $urandom, rnd_val(), rnd_val(), rnd_val());
                    default: send(kfs_pkg::MODE_SAMPLE,
                                  32'($signed($urandom_range(0, 32'h00100000)) - 32'h00020000),
                                  rnd_val(), rnd_val(), rnd_val());
                endcase
            end
            drain();
        end

        $display("%0d items accepted, %0d samples checked (%0d mixed, %0d fallback)",
                 accepted, produced, mixes, fallbacks);
        $display("clamp and wrap modes, zero and extreme durations, full tracks and stalls");
        if (errors == 0 && pending_samples.size() == 0) begin
            $display("keyframe_vec3_sampler verification clean");
        end else begin
            $display("keyframe_vec3_sampler verification failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/kfs_pkg.sv
rtl/core/kfs_divider.sv
rtl/core/keyframe_vec3_sampler.sv
tb/testbench.sv
